[rtl/pcc_pkg.sv]
// Shared types and constants for the clamped PID corrector.
package pcc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_P_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_D_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 3'd5;

  // sequencer steps, one multiplier launch per step where needed
  typedef enum logic [3:0] {
    S_IDLE,  // wait for an error sample
    S_P,     // kp * |e|
    S_Q0,    // prop clamp; |e| * reciprocal
    S_Q1,    // q0 * rate
    S_FIX,   // quotient correction; |diff| * rate
    S_ACC,   // error sum update; kd * m[31:0]
    S_D2,    // kd * m[47:32]; |sum|
    S_DSUM,  // derivative product merge; ki * |sum| high
    S_I1,    // derivative clamp; ki * |sum| low
    S_I2,    // integral merge; dead zone
    S_SAT,   // saturate and restore signs
    S_CMD    // command sum, hand result to output register
  } pcc_state_t;

  typedef struct packed {
    pcc_state_t state;
    logic       in_ready;
    logic       emit;
  } pcc_ctl_t;

endpackage

[rtl/pcc_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
module pcc_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod_r
);

  // register every product before it is used
  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

endmodule

[rtl/pcc_ctrl.sv]
// Sequencer that steps one error sample through the shared multiplier.
module pcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  output pcc_pkg::pcc_ctl_t ctl
);

  pcc_pkg::pcc_state_t state_r, state_nxt;

  // hold the current step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // advance through the fixed schedule
  always_comb begin
    state_nxt    = state_r;
    ctl.state    = state_r;
    ctl.in_ready = 1'b0;
    ctl.emit     = 1'b0;
    case (state_r)
      pcc_pkg::S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) state_nxt = pcc_pkg::S_P;
      end
      pcc_pkg::S_P:    state_nxt = pcc_pkg::S_Q0;
      pcc_pkg::S_Q0:   state_nxt = pcc_pkg::S_Q1;
      pcc_pkg::S_Q1:   state_nxt = pcc_pkg::S_FIX;
      pcc_pkg::S_FIX:  state_nxt = pcc_pkg::S_ACC;
      pcc_pkg::S_ACC:  state_nxt = pcc_pkg::S_D2;
      pcc_pkg::S_D2:   state_nxt = pcc_pkg::S_DSUM;
      pcc_pkg::S_DSUM: state_nxt = pcc_pkg::S_I1;
      pcc_pkg::S_I1:   state_nxt = pcc_pkg::S_I2;
      pcc_pkg::S_I2:   state_nxt = pcc_pkg::S_SAT;
      pcc_pkg::S_SAT:  state_nxt = pcc_pkg::S_CMD;
      pcc_pkg::S_CMD: begin
        if (out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = pcc_pkg::S_IDLE;
        end
      end
      default: state_nxt = pcc_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/pid_corrector_clamped_deadzone.sv]
// One PID channel in signed Q16.16 with clamped P and D terms and a D dead zone.
//
// Input: one error sample per transaction on in_tvalid/in_tready/in_tdata.
// Output: one transaction per sample carrying command and the three terms.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, ready outside reset;
// indexes 0..5 are kp, ki, kd, p_limit, d_limit, dead_zone, others ignored.
// Write configuration only while no sample is in flight.
//
// Timing: a sample is taken in the idle step and worked through the steps of
// the sequencer; its result is loaded into the output register from the final
// step, and the block is ready again the cycle after that. The schedule is set
// by the eight products that share one 32x32 multiplier under the sequencer.
// The output register parts the two sides: a new sample is accepted while
// a result waits, but the sequencer holds at its last step until the waiting
// result has been taken.
// Reset (synchronous, rst_n low) clears the error sum and last error, loads
// the default gains and limits, and drops out_tvalid, in_tready and cfg_ready.
module pid_corrector_clamped_deadzone #(
  parameter int unsigned SAMPLE_RATE_HZ = 250
) (
  input  logic          clk,
  input  logic          rst_n,
  // input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // [31:0] error_in
  // result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // [31:0] command, [63:32] prop_term,
                                    // [95:64] integ_term, [127:96] deriv_term
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam logic [15:0] RATE  = 16'(SAMPLE_RATE_HZ);
  // floor((2^32-1)/rate): quotient estimate is low by at most one
  localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / SAMPLE_RATE_HZ);
  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

  // configuration registers
  logic [31:0] kp_gain_r, ki_gain_r, kd_gain_r;
  logic [30:0] p_limit_r, d_limit_r, dead_zone_r;

  // state kept across samples
  logic [47:0] error_sum_r;
  logic [31:0] last_error_r;

  // per-sample working registers
  logic [31:0] e_r;
  logic        neg_e_r;
  logic [31:0] abs_e_r;
  logic [32:0] diff_r;
  logic [31:0] abs_diff_r;
  logic [30:0] prop_mag_r;
  logic [31:0] q0_r;
  logic [31:0] q_r;
  logic [47:0] m_r;
  logic [63:0] dlo_r;
  logic [47:0] abs_sum_r;
  logic        neg_s_r;
  logic [79:0] dfull_r;
  logic [30:0] dmag_r;
  logic [63:0] ihi_r;
  logic [63:0] ifull_r;
  logic [30:0] dz_r;
  logic [31:0] prop_r, integ_r, deriv_r;

  logic          out_valid_r;
  logic [127:0]  out_data_r;

  pcc_pkg::pcc_ctl_t ctl;
  logic [31:0] op_a, op_b;
  logic [63:0] prod_r;

  logic        in_fire;
  logic        out_free;
  logic [31:0] rem;
  logic [48:0] sum_new;
  logic [31:0] imag;
  logic [33:0] cmd_sum;
  logic [31:0] cmd_sat;

  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = ctl.in_ready & rst_n;
  assign cfg_ready = rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  pcc_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // select multiplier operands for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctl.state)
      pcc_pkg::S_P:    begin op_a = kp_gain_r;       op_b = abs_e_r;                 end
      pcc_pkg::S_Q0:   begin op_a = abs_e_r;         op_b = RECIP;                   end
      pcc_pkg::S_Q1:   begin op_a = prod_r[63:32];   op_b = {16'd0, RATE};           end
      pcc_pkg::S_FIX:  begin op_a = abs_diff_r;      op_b = {16'd0, RATE};           end
      pcc_pkg::S_ACC:  begin op_a = kd_gain_r;       op_b = prod_r[31:0];            end
      pcc_pkg::S_D2:   begin op_a = kd_gain_r;       op_b = {16'd0, m_r[47:32]};     end
      pcc_pkg::S_DSUM: begin op_a = ki_gain_r;       op_b = abs_sum_r[47:16];        end
      pcc_pkg::S_I1:   begin op_a = ki_gain_r;       op_b = {16'd0, abs_sum_r[15:0]}; end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // quotient remainder and error sum, widened by one bit to detect overflow
  assign rem     = abs_e_r - prod_r[31:0];
  assign sum_new = neg_e_r ? ({error_sum_r[47], error_sum_r} - {17'd0, q_r})
                           : ({error_sum_r[47], error_sum_r} + {17'd0, q_r});

  // integral magnitude limited to the signed 32-bit range
  always_comb begin
    if (neg_s_r) begin
      imag = (ifull_r > 64'h8000_0000) ? 32'h8000_0000 : ifull_r[31:0];
    end else begin
      imag = (ifull_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ifull_r[31:0];
    end
  end

  // command sum saturated to 32 bits
  assign cmd_sum = {{2{prop_r[31]}}, prop_r} + {{2{integ_r[31]}}, integ_r}
                 + {{2{deriv_r[31]}}, deriv_r};
  always_comb begin
    if (!cmd_sum[33] && (cmd_sum[32:31] != 2'b00)) begin
      cmd_sat = 32'h7FFF_FFFF;
    end else if (cmd_sum[33] && (cmd_sum[32:31] != 2'b11)) begin
      cmd_sat = 32'h8000_0000;
    end else begin
      cmd_sat = cmd_sum[31:0];
    end
  end

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r   <= 32'd65536;
      ki_gain_r   <= '0;
      kd_gain_r   <= '0;
      p_limit_r   <= 31'h7FFF_FFFF;
      d_limit_r   <= 31'h7FFF_FFFF;
      dead_zone_r <= 31'd131072;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcc_pkg::CFG_KP_GAIN:   kp_gain_r   <= cfg_data;
        pcc_pkg::CFG_KI_GAIN:   ki_gain_r   <= cfg_data;
        pcc_pkg::CFG_KD_GAIN:   kd_gain_r   <= cfg_data;
        pcc_pkg::CFG_P_LIMIT:   p_limit_r   <= cfg_data[30:0];
        pcc_pkg::CFG_D_LIMIT:   d_limit_r   <= cfg_data[30:0];
        pcc_pkg::CFG_DEAD_ZONE: dead_zone_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // update the controller state kept across samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      if (ctl.state == pcc_pkg::S_ACC) begin
        if (sum_new[48] != sum_new[47]) begin
          error_sum_r <= sum_new[48] ? SUM_MIN : SUM_MAX;
        end else begin
          error_sum_r <= sum_new[47:0];
        end
      end
      if (ctl.emit) last_error_r <= e_r;
    end
  end

  // work through one sample, one step per cycle while the final step is not held by a waiting result
  always_ff @(posedge clk) begin
    case (ctl.state)
      pcc_pkg::S_IDLE: begin
        if (in_fire) begin
          e_r     <= in_tdata;
          neg_e_r <= in_tdata[31];
          abs_e_r <= in_tdata[31] ? (32'd0 - in_tdata) : in_tdata;
        end
      end
      pcc_pkg::S_P: begin
        diff_r <= {e_r[31], e_r} - {last_error_r[31], last_error_r};
      end
      pcc_pkg::S_Q0: begin
        prop_mag_r <= (prod_r > {17'd0, p_limit_r, 16'd0}) ? p_limit_r : prod_r[46:16];
        abs_diff_r <= diff_r[32] ? 32'(33'd0 - diff_r) : diff_r[31:0];
      end
      pcc_pkg::S_Q1: begin
        q0_r <= prod_r[63:32];
      end
      pcc_pkg::S_FIX: begin
        q_r <= ({16'd0, RATE} <= rem) ? (q0_r + 32'd1) : q0_r;
      end
      pcc_pkg::S_ACC: begin
        m_r <= prod_r[47:0];
      end
      pcc_pkg::S_D2: begin
        dlo_r     <= prod_r;
        neg_s_r   <= error_sum_r[47];
        abs_sum_r <= error_sum_r[47] ? (48'd0 - error_sum_r) : error_sum_r;
      end
      pcc_pkg::S_DSUM: begin
        dfull_r <= {prod_r[47:0], 32'd0} + {16'd0, dlo_r};
      end
      pcc_pkg::S_I1: begin
        dmag_r <= (dfull_r > {33'd0, d_limit_r, 16'd0}) ? d_limit_r : dfull_r[46:16];
        ihi_r  <= prod_r;
      end
      pcc_pkg::S_I2: begin
        ifull_r <= ihi_r + {16'd0, prod_r[63:16]};
        dz_r    <= (dmag_r > dead_zone_r) ? (dmag_r - dead_zone_r) : '0;
      end
      pcc_pkg::S_SAT: begin
        prop_r  <= neg_e_r ? (32'd0 - {1'b0, prop_mag_r}) : {1'b0, prop_mag_r};
        integ_r <= neg_s_r ? (32'd0 - imag) : imag;
        deriv_r <= diff_r[32] ? (32'd0 - {1'b0, dz_r}) : {1'b0, dz_r};
      end
      default: ;
    endcase
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r <= {deriv_r, integ_r, prop_r, cmd_sat};
    end
  end

  // a taken sample makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready after a sample was taken");

  // a new result appears only from the final step
  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(ctl.state == pcc_pkg::S_CMD))
    else $error("result raised outside the final step");

  // the final step waits while an earlier result is still held
  a_wait_for_receiver: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.state == pcc_pkg::S_CMD) && out_tvalid && !out_tready
      |=> (ctl.state == pcc_pkg::S_CMD))
    else $error("sequencer left the final step while the output was stalled");

endmodule
